FILE: sv/sos_pkg.sv
// Shared types and constants for the sphere overlap pushback pipeline.
// No dependencies.
`timescale 1ns / 1ps
package sos_pkg;
  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int MagW   = 32;
  localparam int RootW  = 32;
  localparam int AXES   = 3;
  localparam int SqrtCells = RootW;
  localparam int DivCells  = 32;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [31:0] NegMax = 32'h8000_0000;

  typedef struct packed {
    logic                      hit;
    logic [AXES-1:0]           d_neg;
    logic [AXES-1:0][MagW-1:0] d_mag;
    logic [31:0]               r;
  } geo_t;

  typedef struct packed {
    logic             valid;
    geo_t             geo;
    logic [33:0]      rem;
    logic [RootW-1:0] root;
    logic [63:0]      n;
  } sqrt_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
  } div_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic                  zero;
    logic [RootW-1:0]      len;
    div_lane_t [AXES-1:0]  lane;
  } div_t;
endpackage

FILE: sv/sos_if.sv
// Valid/ready channel interfaces for sphere pairs and push results.
// Depends on sos_pkg.
`timescale 1ns / 1ps
interface sos_pair_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [sos_pkg::CoordW-1:0] a_center_x, a_center_y, a_center_z;
  logic [sos_pkg::RadW-1:0] a_radius;
  logic signed [sos_pkg::CoordW-1:0] b_center_x, b_center_y, b_center_z;
  logic [sos_pkg::RadW-1:0] b_radius;
  modport source (output valid, a_center_x, a_center_y, a_center_z, a_radius,
                  b_center_x, b_center_y, b_center_z, b_radius, input ready);
  modport sink (input valid, a_center_x, a_center_y, a_center_z, a_radius,
                b_center_x, b_center_y, b_center_z, b_radius, output ready);
endinterface

interface sos_push_if (input logic clk);
  logic valid;
  logic ready;
  logic hit;
  logic signed [sos_pkg::CoordW-1:0] push_x, push_y, push_z;
  modport source (output valid, hit, push_x, push_y, push_z, input ready);
  modport sink (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

FILE: sv/sphere_overlap_pushback.sv
// Top level: sphere pair overlap test and pushback vector, fully pipelined.
// Depends on sos_pkg, sos_if, sos_sqrt_cell, sos_div_cell.
`timescale 1ns / 1ps
//
//  channel | dir | modport | beat
//  --------+-----+---------+-----------------------------------------------
//  pair    | in  | sink    | A/B centers (Q15.16 signed), radii (Q15.16)
//  resp    | out | source  | hit flag, push_x/y/z (Q15.16, saturated)
//
// One beat in per cycle, one beat out per cycle, unless the output stalls.
// Stages: input register, squares, sum/compare, 32 root cells (one root bit
// each), multiply by penetration, 32 divider cells (one quotient bit each),
// output register. The whole pipe advances together whenever the output
// register is empty or being taken; pair.ready falls only while a result
// waits at the output. rst clears every stage's valid bit.
module sphere_overlap_pushback (
  input  logic clk,
  input  logic rst,
  sos_pair_if.sink   pair,
  sos_push_if.source resp
);
  logic en;
  assign en = !resp.valid || resp.ready;
  assign pair.ready = en;

  // Stage 0: per-axis difference A - B as sign and magnitude, summed radii
  logic                                   s0_valid;
  sos_pkg::geo_t                          s0_geo;
  logic [sos_pkg::AXES-1:0][32:0]         dif;

  always_comb begin
    dif[0] = {pair.a_center_x[31], pair.a_center_x} - {pair.b_center_x[31], pair.b_center_x};
    dif[1] = {pair.a_center_y[31], pair.a_center_y} - {pair.b_center_y[31], pair.b_center_y};
    dif[2] = {pair.a_center_z[31], pair.a_center_z} - {pair.b_center_z[31], pair.b_center_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pair.valid;
    end
    if (en) begin
      s0_geo.hit <= 1'b0;
      for (int i = 0; i < sos_pkg::AXES; i++) begin
        s0_geo.d_neg[i] <= dif[i][32];
        // magnitude never exceeds 2^32 - 1
        s0_geo.d_mag[i] <= dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
      end
      s0_geo.r <= {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
    end
  end

  // Stage 1: squares of each axis and of the summed radii
  logic                                   s1_valid;
  sos_pkg::geo_t                          s1_geo;
  logic [sos_pkg::AXES-1:0][63:0]         s1_sq;
  logic [63:0]                            s1_rsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
    if (en) begin
      s1_geo <= s0_geo;
      for (int i = 0; i < sos_pkg::AXES; i++) begin
        s1_sq[i] <= 64'(s0_geo.d_mag[i]) * 64'(s0_geo.d_mag[i]);
      end
      s1_rsq <= 64'(s0_geo.r) * 64'(s0_geo.r);
    end
  end

  // Stage 2: squared length, inclusive hit test; a sum past 64 bits misses
  logic [65:0]    sum;
  logic           s2_hit;
  sos_pkg::geo_t  s2_geo;
  sos_pkg::sqrt_t sq_chain [sos_pkg::SqrtCells+1];

  always_comb begin
    sum    = {2'b00, s1_sq[0]} + {2'b00, s1_sq[1]} + {2'b00, s1_sq[2]};
    s2_hit = (sum[65:64] == 2'b00) && (sum[63:0] <= s1_rsq);
    s2_geo     = s1_geo;
    s2_geo.hit = s2_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_chain[0].valid <= 1'b0;
    end else if (en) begin
      sq_chain[0].valid <= s1_valid;
    end
    if (en) begin
      sq_chain[0].geo     <= s2_geo;
      sq_chain[0].rem     <= '0;
      sq_chain[0].root    <= '0;
      sq_chain[0].n       <= sum[63:0];
    end
  end

  // Floor square root, one root bit per cell
  for (genvar k = 0; k < sos_pkg::SqrtCells; k++) begin : g_sqrt
    sos_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq_chain[k]),
      .dout (sq_chain[k+1])
    );
  end

  // Multiply stage: |d| * penetration, divider preload
  sos_pkg::sqrt_t sq_last;
  logic [31:0]    pen;
  logic [sos_pkg::AXES-1:0][63:0] prod;
  sos_pkg::div_t  dv_chain [sos_pkg::DivCells+1];

  always_comb begin
    sq_last = sq_chain[sos_pkg::SqrtCells];
    pen = sq_last.geo.r - sq_last.root;
    for (int i = 0; i < sos_pkg::AXES; i++) begin
      prod[i] = 64'(sq_last.geo.d_mag[i]) * 64'(pen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_chain[0].valid <= 1'b0;
    end else if (en) begin
      dv_chain[0].valid <= sq_last.valid;
    end
    if (en) begin
      dv_chain[0].hit  <= sq_last.geo.hit;
      dv_chain[0].zero <= (sq_last.root == '0);
      dv_chain[0].len  <= sq_last.root;
      for (int i = 0; i < sos_pkg::AXES; i++) begin
        dv_chain[0].lane[i].neg <= sq_last.geo.d_neg[i];
        // quotient would reach 2^32: saturates regardless of sign
        dv_chain[0].lane[i].sat <= (prod[i][63:32] >= sq_last.root);
        dv_chain[0].lane[i].rem <= prod[i][63:32];
        dv_chain[0].lane[i].lo  <= prod[i][31:0];
        dv_chain[0].lane[i].q   <= '0;
      end
    end
  end

  // Restoring divide by distance, one quotient bit per cell
  for (genvar k = 0; k < sos_pkg::DivCells; k++) begin : g_div
    sos_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dv_chain[k]),
      .dout (dv_chain[k+1])
    );
  end

  // Output register: sign, saturation, miss and coincident-center zeroing
  sos_pkg::div_t dv_last;
  logic [sos_pkg::AXES-1:0][31:0] push_next;

  always_comb begin
    dv_last = dv_chain[sos_pkg::DivCells];
    for (int i = 0; i < sos_pkg::AXES; i++) begin
      if (!dv_last.hit || dv_last.zero) begin
        push_next[i] = '0;
      end else if (dv_last.lane[i].neg) begin
        if (dv_last.lane[i].sat || dv_last.lane[i].q > sos_pkg::NegMax) begin
          push_next[i] = sos_pkg::NegMax;
        end else begin
          push_next[i] = 32'(-dv_last.lane[i].q);
        end
      end else begin
        if (dv_last.lane[i].sat || dv_last.lane[i].q > sos_pkg::PosMax) begin
          push_next[i] = sos_pkg::PosMax;
        end else begin
          push_next[i] = dv_last.lane[i].q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp.valid <= 1'b0;
    end else if (en) begin
      resp.valid <= dv_last.valid;
    end
    if (en) begin
      resp.hit    <= dv_last.hit;
      resp.push_x <= push_next[0];
      resp.push_y <= push_next[1];
      resp.push_z <= push_next[2];
    end
  end

  // A miss never carries a push
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    resp.valid && !resp.hit |-> resp.push_x == 0 && resp.push_y == 0 && resp.push_z == 0)
    else $error("miss with nonzero push");

  // Input backpressure only while a result sits unclaimed
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pair.ready |-> resp.valid && !resp.ready)
    else $error("input stalled without output stall");

  // On a hit the distance never exceeds the summed radii
  a_pen_pos: assert property (@(posedge clk) disable iff (rst)
    sq_last.valid && sq_last.geo.hit |-> sq_last.root <= sq_last.geo.r)
    else $error("negative penetration on hit");

  // Pipe frozen while stalled
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_chain[0].valid) && $stable(sq_chain[0].valid))
    else $error("pipe moved during stall");
endmodule

FILE: sv/sos_sqrt_cell.sv
// One digit of the square root chain: two radicand bits in, one root bit out.
// Depends on sos_pkg.
`timescale 1ns / 1ps
module sos_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sos_pkg::sqrt_t din,
  output sos_pkg::sqrt_t dout
);
  logic [33:0] rem2;
  logic [33:0] trial;
  sos_pkg::sqrt_t dout_next;

  always_comb begin
    rem2  = {din.rem[31:0], din.n[63:62]};
    trial = {din.root, 2'b01};
    dout_next = din;
    dout_next.n = {din.n[61:0], 2'b00};
    if (rem2 >= trial) begin
      dout_next.rem  = rem2 - trial;
      dout_next.root = {din.root[30:0], 1'b1};
    end else begin
      dout_next.rem  = rem2;
      dout_next.root = {din.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.geo  <= dout_next.geo;
      dout.rem  <= dout_next.rem;
      dout.root <= dout_next.root;
      dout.n    <= dout_next.n;
    end
  end
endmodule

FILE: sv/sos_div_cell.sv
// One quotient bit of the restoring divider, three axes side by side.
// Depends on sos_pkg.
`timescale 1ns / 1ps
module sos_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  sos_pkg::div_t din,
  output sos_pkg::div_t dout
);
  logic [sos_pkg::AXES-1:0][32:0] r2;
  sos_pkg::div_t dout_next;

  always_comb begin
    dout_next = din;
    for (int i = 0; i < sos_pkg::AXES; i++) begin
      r2[i] = {din.lane[i].rem, din.lane[i].lo[31]};
      dout_next.lane[i].lo = {din.lane[i].lo[30:0], 1'b0};
      if (r2[i] >= {1'b0, din.len}) begin
        dout_next.lane[i].rem = 32'(r2[i] - {1'b0, din.len});
        dout_next.lane[i].q   = {din.lane[i].q[30:0], 1'b1};
      end else begin
        dout_next.lane[i].rem = r2[i][31:0];
        dout_next.lane[i].q   = {din.lane[i].q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.hit  <= dout_next.hit;
      dout.zero <= dout_next.zero;
      dout.len  <= dout_next.len;
      dout.lane <= dout_next.lane;
    end
  end
endmodule
